// ===== hdl/somu_pkg.sv =====
// ----------------------------------------------------------------------------
// Symmetry orbit multiplicity package
// Shared widths, register indexes and the per-stage pipeline record.
// ----------------------------------------------------------------------------
`default_nettype none

package somu_pkg;

    localparam int STATE_W = 16;
    localparam int MAP_W   = 64;
    localparam int MULT_W  = 5;
    localparam int NIB_W   = 4;

    typedef enum logic [0:0] {
        REG_SITE_MAP = 1'b0,
        REG_PERIOD   = 1'b1
    } somu_reg_t;

    localparam logic [MAP_W-1:0]  SITE_MAP_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [MULT_W-1:0] PERIOD_RESET   = 5'd1;

    typedef struct packed {
        logic [STATE_W-1:0] orig;
        logic [STATE_W-1:0] img;
        logic [MULT_W-1:0]  period;
        logic [MULT_W-1:0]  mult;
        logic               rep;
        logic               done;
    } somu_item_t;

endpackage

`default_nettype wire

// ===== hdl/symmetry_orbit_multiplicity_unit.sv =====
// ----------------------------------------------------------------------------
// Symmetry orbit multiplicity unit
// Representative-state check and orbit multiplicity under a site permutation.
// ----------------------------------------------------------------------------
// One basis state enters per cycle while in_ready is high. Each pipeline stage
// applies the configured site permutation once and compares the image with the
// original; each stage is registered, and throughput is one state per cycle
// while the output side takes results. Write site_map and period only while
// the pipeline is empty.
`default_nettype none

module symmetry_orbit_multiplicity_unit #(
    parameter int SITES      = 16,
    parameter int MAX_PERIOD = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [somu_pkg::MAP_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [somu_pkg::STATE_W-1:0]  state_bits,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               is_representative,
    output logic [somu_pkg::MULT_W-1:0]        multiplicity
);

    localparam int MULT_MAX = (1 << somu_pkg::MULT_W) - 1;
    localparam int STEPS    = (MAX_PERIOD < MULT_MAX) ? MAX_PERIOD : MULT_MAX;
    localparam logic [somu_pkg::STATE_W-1:0] SITE_MASK =
        somu_pkg::STATE_W'((32'd1 << SITES) - 32'd1);
    localparam logic [somu_pkg::MULT_W-1:0] PMAX_V = somu_pkg::MULT_W'(STEPS);

    logic [somu_pkg::MAP_W-1:0]  site_map_reg;
    logic [somu_pkg::MULT_W-1:0] period_reg;
    logic [somu_pkg::MULT_W-1:0] period_eff;
    somu_pkg::somu_item_t        entry;

    logic                 stg_valid [STEPS+1];
    logic                 stg_ready [STEPS+1];
    somu_pkg::somu_item_t stg_item  [STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_map_reg <= somu_pkg::SITE_MAP_RESET;
            period_reg   <= somu_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (somu_pkg::somu_reg_t'(cfg_index))
                somu_pkg::REG_SITE_MAP: site_map_reg <= cfg_data;
                somu_pkg::REG_PERIOD:   period_reg   <= cfg_data[somu_pkg::MULT_W-1:0];
                default:                period_reg   <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        priority if (period_reg == '0)
        begin
            period_eff = somu_pkg::MULT_W'(1);
        end
        else if ((MAX_PERIOD < MULT_MAX) && (period_reg > PMAX_V))
        begin
            period_eff = PMAX_V;
        end
        else
        begin
            period_eff = period_reg;
        end
    end

    always_comb
    begin
        entry.orig   = state_bits & SITE_MASK;
        entry.img    = state_bits & SITE_MASK;
        entry.period = period_eff;
        entry.mult   = period_eff;
        entry.rep    = 1'b1;
        entry.done   = 1'b0;
    end

    assign stg_valid[0] = in_valid;
    assign stg_item[0]  = entry;
    assign in_ready     = stg_ready[0];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_stage
        somu_stage #(
            .SITES (SITES),
            .STEP  (k + 1)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .site_map  (site_map_reg),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    assign stg_ready[STEPS]  = out_ready;
    assign out_valid         = stg_valid[STEPS];
    assign is_representative = stg_item[STEPS].rep;
    assign multiplicity      = stg_item[STEPS].mult;

endmodule

`default_nettype wire

// ===== hdl/somu_stage.sv =====
// ----------------------------------------------------------------------------
// Symmetry orbit multiplicity pipeline stage
// Permutes an open item within its period once; compares image and original.
// ----------------------------------------------------------------------------
`default_nettype none

module somu_stage #(
    parameter int SITES = 16,
    parameter int STEP  = 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [somu_pkg::MAP_W-1:0]   site_map,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire somu_pkg::somu_item_t         in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output somu_pkg::somu_item_t              out_item
);

    localparam logic [somu_pkg::MULT_W-1:0] STEP_V = somu_pkg::MULT_W'(STEP);

    logic                       valid_reg;
    logic                       valid_next;
    somu_pkg::somu_item_t       item_reg;
    somu_pkg::somu_item_t       item_next;
    logic [somu_pkg::STATE_W-1:0] img_perm;
    logic                       active;

    always_comb
    begin
        img_perm = '0;
        for (int i = 0; i < SITES; i++)
        begin
            if (int'(site_map[somu_pkg::NIB_W*i +: somu_pkg::NIB_W]) < SITES)
            begin
                img_perm[site_map[somu_pkg::NIB_W*i +: somu_pkg::NIB_W]] = in_item.img[i];
            end
        end
    end

    assign active = !in_item.done && (STEP_V <= in_item.period);

    always_comb
    begin
        item_next = in_item;
        if (active)
        begin
            item_next.img = img_perm;
            if (img_perm < in_item.orig)
            begin
                item_next.rep  = 1'b0;
                item_next.mult = '0;
                item_next.done = 1'b1;
            end
            else if (img_perm == in_item.orig)
            begin
                item_next.mult = STEP_V;
                item_next.done = 1'b1;
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/somu_checker.sv =====
// ----------------------------------------------------------------------------
// Symmetry orbit multiplicity checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module somu_checker #(
    parameter int MAX_PERIOD = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          is_representative,
    input wire logic [somu_pkg::MULT_W-1:0]   multiplicity
);

    a_rep_mult: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_representative == (multiplicity != '0)))
        else $error("multiplicity disagrees with representative flag");

    a_mult_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(multiplicity) <= MAX_PERIOD))
        else $error("multiplicity above maximum period");

    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result presented right after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(is_representative) && $stable(multiplicity)))
        else $error("stalled result changed or dropped");

    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("request refused while the output side drains");

endmodule

bind symmetry_orbit_multiplicity_unit somu_checker #(
    .MAX_PERIOD (MAX_PERIOD)
) u_somu_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .is_representative (is_representative),
    .multiplicity      (multiplicity)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry orbit multiplicity unit testbench
// Streams basis states through the unit under many site maps and periods,
// predicts the representative flag and orbit multiplicity of every request,
// and checks the results in order while both handshakes idle and stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SITES       = 16;
    localparam int MAX_PERIOD  = 16;
    localparam int LATENCY     = MAX_PERIOD;
    localparam int MAX_IDLE    = 14;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [somu_pkg::STATE_W-1:0] state;
        logic                         rep;
        logic [somu_pkg::MULT_W-1:0]  mult;
    } orbit_res_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic                          cfg_index;
    logic [somu_pkg::MAP_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [somu_pkg::STATE_W-1:0]  state_bits;
    logic                          out_valid;
    logic                          out_ready;
    logic                          is_representative;
    logic [somu_pkg::MULT_W-1:0]   multiplicity;

    logic [somu_pkg::MAP_W-1:0]    map_q;
    logic [somu_pkg::MULT_W-1:0]   period_q;
    orbit_res_t                    orbit_q[$];
    orbit_res_t                    head_exp;
    int                            errors;
    int                            cycles = 0;
    int                            tx_max_gap;
    int                            rx_max_stall;
    int                            rx_hold;

    symmetry_orbit_multiplicity_unit #(
        .SITES      (SITES),
        .MAX_PERIOD (MAX_PERIOD)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .state_bits        (state_bits),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .is_representative (is_representative),
        .multiplicity      (multiplicity)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [somu_pkg::STATE_W-1:0] apply_map(
        input logic [somu_pkg::STATE_W-1:0] s);
        logic [somu_pkg::STATE_W-1:0] nxt;
        logic [somu_pkg::NIB_W-1:0]   dst;
        int                           i;
        nxt = '0;
        // later sources overwrite earlier ones on a shared destination
        for (i = 0; i < SITES; i++)
        begin
            dst = map_q[somu_pkg::NIB_W*i +: somu_pkg::NIB_W];
            nxt[dst] = s[i];
        end
        return nxt;
    endfunction

    function automatic orbit_res_t orbit_check(input logic [somu_pkg::STATE_W-1:0] s);
        orbit_res_t                   r;
        logic [somu_pkg::STATE_W-1:0] img;
        int                           steps;
        int                           k;
        logic                         done;
        if (period_q == 0)
            steps = 1;
        else if (period_q > MAX_PERIOD)
            steps = MAX_PERIOD;
        else
            steps = int'(period_q);
        r.state = s;
        r.rep   = 1'b1;
        r.mult  = somu_pkg::MULT_W'(steps);
        img     = s;
        done    = 1'b0;
        for (k = 0; k < steps && !done; k++)
        begin
            img = apply_map(img);
            if (img < s)
            begin
                r.rep  = 1'b0;
                r.mult = '0;
                done   = 1'b1;
            end
            else if (img == s)
            begin
                r.mult = somu_pkg::MULT_W'(k + 1);
                done   = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [somu_pkg::MAP_W-1:0] random_perm_map();
        int                         perm [SITES];
        int                         i;
        int                         j;
        int                         t;
        logic [somu_pkg::MAP_W-1:0] m;
        for (i = 0; i < SITES; i++)
            perm[i] = i;
        for (i = SITES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        m = '0;
        for (i = 0; i < SITES; i++)
            m[somu_pkg::NIB_W*i +: somu_pkg::NIB_W] = somu_pkg::NIB_W'(perm[i]);
        return m;
    endfunction

    // rotate sites by r inside groups of grp sites
    function automatic logic [somu_pkg::MAP_W-1:0] rotate_map(input int r, input int grp);
        logic [somu_pkg::MAP_W-1:0] m;
        int                         i;
        m = '0;
        for (i = 0; i < SITES; i++)
            m[somu_pkg::NIB_W*i +: somu_pkg::NIB_W] =
                somu_pkg::NIB_W'((i / grp) * grp + (i % grp + r) % grp);
        return m;
    endfunction

    function automatic logic [somu_pkg::STATE_W-1:0] pick_state();
        logic [somu_pkg::STATE_W-1:0] s;
        logic [3:0]                   n;
        n = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0: s = somu_pkg::STATE_W'($urandom_range(0, 16'hFFFF));
            1: s = (16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15));
            2: s = ~((16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15)));
            default: s = {4{n}};
        endcase
        return s;
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic write_reg(input somu_pkg::somu_reg_t idx,
                             input logic [somu_pkg::MAP_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == somu_pkg::REG_SITE_MAP)
            map_q = data;
        else
            period_q = data[somu_pkg::MULT_W-1:0];
    endtask

    task automatic send_state(input logic [somu_pkg::STATE_W-1:0] s);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        state_bits <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        orbit_q.push_back(orbit_check(s));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (orbit_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // receiver: stall a random number of cycles, or rx_hold when set, before each result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, rx_max_stall);
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (orbit_q.size() == 0)
                report("result with no request pending");
            else
            begin
                head_exp = orbit_q.pop_front();
                if (is_representative !== head_exp.rep)
                    report($sformatf("state %h: is_representative %b, want %b",
                                     head_exp.state, is_representative, head_exp.rep));
                if (multiplicity !== head_exp.mult)
                    report($sformatf("state %h: multiplicity %0d, want %0d",
                                     head_exp.state, multiplicity, head_exp.mult));
            end
        end
    end

    task automatic test_reset_identity();
        send_state(16'h0000);
        send_state(16'hFFFF);
        send_state(16'h8000);
        send_state(16'h0001);
    endtask

    task automatic test_rotation_orbits();
        wait_idle();
        write_reg(somu_pkg::REG_SITE_MAP, rotate_map(1, SITES));
        write_reg(somu_pkg::REG_PERIOD, somu_pkg::MAP_W'(MAX_PERIOD));
        send_state(16'h0001);
        send_state(16'h8000);
        send_state(16'h5555);
        send_state(16'h1111);
        send_state(16'h0000);
        send_state(16'hFFFF);
    endtask

    task automatic test_period_limits();
        wait_idle();
        write_reg(somu_pkg::REG_PERIOD, '0);
        send_state(16'h0001);
        wait_idle();
        write_reg(somu_pkg::REG_PERIOD, somu_pkg::MAP_W'(MAX_PERIOD + 1));
        send_state(16'h0001);
        wait_idle();
        write_reg(somu_pkg::REG_PERIOD, {59'h5A5_A5A5_A5A5_A5A5, 5'd31});
        send_state(16'h5555);
        wait_idle();
        write_reg(somu_pkg::REG_PERIOD, 64'd8);
        send_state(16'h0001);
    endtask

    task automatic test_colliding_maps();
        wait_idle();
        write_reg(somu_pkg::REG_SITE_MAP, '0);
        write_reg(somu_pkg::REG_PERIOD, 64'd4);
        send_state(16'h8000);
        send_state(16'h0001);
        send_state(16'h0000);
        send_state(16'hFFFF);
        wait_idle();
        write_reg(somu_pkg::REG_SITE_MAP, '1);
        send_state(16'h8000);
        send_state(16'h7FFF);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        logic [somu_pkg::MAP_W-1:0] m;
        logic [somu_pkg::MAP_W-1:0] pv;
        int                         p;
        int                         n;
        int                         sel;
        for (p = 0; p < phases; p++)
        begin
            wait_idle();
            sel = $urandom_range(0, 9);
            if (sel < 5)
                m = random_perm_map();
            else if (sel < 7)
                m = rotate_map($urandom_range(0, SITES - 1), 1 << $urandom_range(1, 4));
            else if (sel < 9)
                m = {$urandom, $urandom};
            else
                m = $urandom_range(0, 1) ? '0 : '1;
            sel = $urandom_range(0, 9);
            if (p == 0 || sel < 2)
                pv = somu_pkg::MAP_W'(MAX_PERIOD);
            else if (sel < 7)
                pv = somu_pkg::MAP_W'($urandom_range(1, MAX_PERIOD));
            else if (sel < 8)
                pv = '0;
            else
                pv = somu_pkg::MAP_W'($urandom_range(MAX_PERIOD + 1, 31));
            if ($urandom_range(0, 3) == 0)
                pv = pv | ({$urandom, $urandom} & ~64'h1F);
            write_reg(somu_pkg::REG_SITE_MAP, m);
            write_reg(somu_pkg::REG_PERIOD, pv);
            case (p % 3)
                0:
                begin
                    tx_max_gap   = MAX_IDLE;
                    rx_max_stall = MAX_IDLE;
                end
                1:
                begin
                    tx_max_gap   = 0;
                    rx_max_stall = 0;
                end
                default:
                begin
                    tx_max_gap   = $urandom_range(0, 1) * MAX_IDLE;
                    rx_max_stall = $urandom_range(0, 1) * MAX_IDLE;
                end
            endcase
            for (n = 0; n < per_phase; n++)
                send_state(pick_state());
        end
        tx_max_gap   = MAX_IDLE;
        rx_max_stall = MAX_IDLE;
    endtask

    task automatic test_backpressure();
        int n;
        wait_idle();
        write_reg(somu_pkg::REG_SITE_MAP, random_perm_map());
        write_reg(somu_pkg::REG_PERIOD, somu_pkg::MAP_W'(MAX_PERIOD));
        tx_max_gap = 0;
        // hold the output long enough for the pipeline to fill
        rx_hold = 300;
        for (n = 0; n < 80; n++)
            send_state(pick_state());
        tx_max_gap = MAX_IDLE;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        state_bits   = '0;
        errors       = 0;
        tx_max_gap   = MAX_IDLE;
        rx_max_stall = MAX_IDLE;
        rx_hold      = 0;
        map_q        = somu_pkg::SITE_MAP_RESET;
        period_q     = somu_pkg::PERIOD_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_identity();
        test_rotation_orbits();
        test_period_limits();
        test_colliding_maps();
        test_random_phases(14, 70);
        test_backpressure();

        wait_idle();
        if (orbit_q.size() != 0)
            report($sformatf("%0d results never arrived", orbit_q.size()));
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
